/* design/dtss_pkg.sv */
// ----------------------------------------------------------------------------
// dtss_pkg: shared types and constants of the deadline task slot scheduler
// Holds the operation and status codes, slot table sizes, the sequencer
// state type and the scan control struct.
// ----------------------------------------------------------------------------
package dtss_pkg;

	localparam int SlotCount = 16;
	localparam int SlotIdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
	localparam int CountW = $clog2(SlotCount + 1);
	localparam int GenW = 24;
	localparam int HandleIdxW = 8;

	typedef enum logic [1:0] {
		OP_SCHEDULE = 2'd0,
		OP_CANCEL   = 2'd1,
		OP_POP      = 2'd2,
		OP_STOP     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_BAD_HANDLE  = 3'd1,
		ST_STOPPING    = 3'd2,
		ST_OVERFLOW    = 3'd3,
		ST_FULL        = 3'd4,
		ST_NOT_PENDING = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_OUT
	} state_t;

	// control from the sequencer to the scan unit
	typedef struct packed {
		logic                clear;
		logic                step;
		logic [SlotIdxW-1:0] idx;
	} scan_ctl_t;

endpackage

/* design/dtss_scan.sv */
// ----------------------------------------------------------------------------
// dtss_scan: shared compare unit for the slot scan
// Visits one slot per cycle and keeps the best ready and best delayed slot
// by due time then sequence, plus the lowest free slot.
// ----------------------------------------------------------------------------
module dtss_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dtss_pkg::scan_ctl_t           ctl,
	input  logic                          used,
	input  logic [63:0]                   due,
	input  logic [63:0]                   order,
	input  logic [63:0]                   now,
	output logic                          rdy_found_q,
	output logic [dtss_pkg::SlotIdxW-1:0] rdy_idx_q,
	output logic                          dly_found_q,
	output logic [63:0]                   dly_due_q,
	output logic                          free_found_q,
	output logic [dtss_pkg::SlotIdxW-1:0] free_idx_q
);

	logic [63:0] rdy_due_q, rdy_ord_q, dly_ord_q;
	logic        is_ready, better_rdy, better_dly;

	// one shared compare path per cycle
	always_comb begin
		is_ready = due <= now;
		better_rdy = !rdy_found_q || (due < rdy_due_q) ||
			(due == rdy_due_q && order < rdy_ord_q);
		better_dly = !dly_found_q || (due < dly_due_q) ||
			(due == dly_due_q && order < dly_ord_q);
	end

	// found flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_found_q <= 1'b0;
			dly_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctl.clear) begin
			rdy_found_q <= 1'b0;
			dly_found_q <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctl.step) begin
			if (used && is_ready && better_rdy) rdy_found_q <= 1'b1;
			if (used && !is_ready && better_dly) dly_found_q <= 1'b1;
			if (!used) free_found_q <= 1'b1;
		end
	end

	// best candidates
	always_ff @(posedge clk) begin
		if (ctl.step) begin
			if (used && is_ready && better_rdy) begin
				rdy_idx_q <= ctl.idx;
				rdy_due_q <= due;
				rdy_ord_q <= order;
			end
			if (used && !is_ready && better_dly) begin
				dly_due_q <= due;
				dly_ord_q <= order;
			end
			if (!used && !free_found_q) free_idx_q <= ctl.idx;
		end
	end

endmodule

/* design/deadline_task_slot_scheduler.sv */
// ----------------------------------------------------------------------------
// deadline_task_slot_scheduler: timer slot table with generation handles
// Top level: slot storage, sequencer and result register.
// ----------------------------------------------------------------------------
// Every word scans the whole table, whatever the operation: one slot of the
// table is visited per cycle by the shared compare unit, then the FINISH
// state applies the update and the OUT state presents the result. stall
// is high from acceptance until the result word has been taken. Handles are
// generation << 8 | (slot + 1); pending_count counts occupied slots after the
// operation.
module deadline_task_slot_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [63:0] now_ms,
	input  logic [63:0] delay_ms,
	input  logic [31:0] task_token,
	input  logic [31:0] handle_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] handle_out,
	output logic [31:0] token_out,
	output logic        executed,
	output logic        has_delayed,
	output logic [63:0] wait_ms,
	output logic [4:0]  pending_count
);

	localparam int N = dtss_pkg::SlotCount;
	localparam int IW = dtss_pkg::SlotIdxW;

	dtss_pkg::state_t state_q, state_nx;
	logic [IW-1:0] idx_q;

	logic [1:0]  op_q;
	logic [63:0] now_q, delay_q;
	logic [31:0] tok_q, hin_q;

	logic [N-1:0] used_q;
	logic [dtss_pkg::GenW-1:0] gen_q [N];
	logic [63:0] due_q [N];
	logic [63:0] ord_q [N];
	logic [31:0] stok_q [N];
	logic [63:0] order_counter_q;
	logic        stopping_q;
	logic [dtss_pkg::CountW-1:0] count_q;

	dtss_pkg::scan_ctl_t ctl;
	logic rdy_found, dly_found, free_found;
	logic [IW-1:0] rdy_idx, free_idx;
	logic [63:0] dly_due;

	logic accept;
	assign accept = in_valid && !in_stall;

	// sequencer next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			dtss_pkg::S_IDLE:   if (in_valid) state_nx = dtss_pkg::S_SCAN;
			dtss_pkg::S_SCAN:   if (idx_q == IW'(N - 1)) state_nx = dtss_pkg::S_FINISH;
			dtss_pkg::S_FINISH: state_nx = dtss_pkg::S_OUT;
			dtss_pkg::S_OUT:    if (!out_stall) state_nx = dtss_pkg::S_IDLE;
			default:            state_nx = dtss_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		out_valid = 1'b0;
		ctl.clear = 1'b0;
		ctl.step = 1'b0;
		ctl.idx = idx_q;
		case (state_q)
			dtss_pkg::S_IDLE: begin
				in_stall = 1'b0;
				ctl.clear = 1'b1;
			end
			dtss_pkg::S_SCAN: ctl.step = 1'b1;
			dtss_pkg::S_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dtss_pkg::S_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == dtss_pkg::S_SCAN) idx_q <= idx_q + IW'(1);
			else idx_q <= '0;
		end
	end

	// captured input word
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			now_q <= now_ms;
			delay_q <= delay_ms;
			tok_q <= task_token;
			hin_q <= handle_in;
		end
	end

	dtss_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.used         (used_q[idx_q]),
		.due          (due_q[idx_q]),
		.order        (ord_q[idx_q]),
		.now          (now_q),
		.rdy_found_q  (rdy_found),
		.rdy_idx_q    (rdy_idx),
		.dly_found_q  (dly_found),
		.dly_due_q    (dly_due),
		.free_found_q (free_found),
		.free_idx_q   (free_idx)
	);

	// decode of the finishing step
	logic [7:0] henc;
	logic [dtss_pkg::GenW-1:0] hgen, new_gen;
	logic [IW-1:0] cidx;
	logic bad_handle, sched_ovf;
	always_comb begin
		henc = hin_q[7:0];
		hgen = hin_q[31:8];
		bad_handle = (henc == 8'd0) || ({1'b0, henc} > 9'(N)) || (hgen == '0);
		cidx = IW'(henc - 8'd1);
		sched_ovf = delay_q > (64'hFFFF_FFFF_FFFF_FFFF - now_q);
		new_gen = gen_q[free_idx] + dtss_pkg::GenW'(1);
		if (new_gen == '0) new_gen = {{(dtss_pkg::GenW-1){1'b0}}, 1'b1};
	end

	logic fin;
	assign fin = state_q == dtss_pkg::S_FINISH;

	// slot table control, order counter, stop flag and pending count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int i = 0; i < N; i++) gen_q[i] <= '0;
			order_counter_q <= '0;
			stopping_q <= 1'b0;
			count_q <= '0;
		end else if (fin) begin
			case (dtss_pkg::op_t'(op_q))
				dtss_pkg::OP_SCHEDULE: begin
					if (!stopping_q && !sched_ovf && free_found) begin
						used_q[free_idx] <= 1'b1;
						gen_q[free_idx] <= new_gen;
						order_counter_q <= order_counter_q + 64'd1;
						count_q <= count_q + 1'b1;
					end
				end
				dtss_pkg::OP_CANCEL: begin
					if (!bad_handle && used_q[cidx] && gen_q[cidx] == hgen) begin
						used_q[cidx] <= 1'b0;
						count_q <= count_q - 1'b1;
					end
				end
				dtss_pkg::OP_POP: begin
					if (!stopping_q && rdy_found) begin
						used_q[rdy_idx] <= 1'b0;
						count_q <= count_q - 1'b1;
					end
				end
				default: stopping_q <= 1'b1;
			endcase
		end
	end

	// payload stores and result word
	always_ff @(posedge clk) begin
		if (fin) begin
			status <= dtss_pkg::ST_OK;
			handle_out <= '0;
			token_out <= '0;
			executed <= 1'b0;
			has_delayed <= 1'b0;
			wait_ms <= '0;
			case (dtss_pkg::op_t'(op_q))
				dtss_pkg::OP_SCHEDULE: begin
					if (stopping_q) status <= dtss_pkg::ST_STOPPING;
					else if (sched_ovf) status <= dtss_pkg::ST_OVERFLOW;
					else if (!free_found) status <= dtss_pkg::ST_FULL;
					else begin
						due_q[free_idx] <= now_q + delay_q;
						ord_q[free_idx] <= order_counter_q + 64'd1;
						stok_q[free_idx] <= tok_q;
						handle_out <= {new_gen, 8'(free_idx) + 8'd1};
					end
				end
				dtss_pkg::OP_CANCEL: begin
					if (bad_handle) status <= dtss_pkg::ST_BAD_HANDLE;
					else if (!used_q[cidx] || gen_q[cidx] != hgen)
						status <= dtss_pkg::ST_NOT_PENDING;
				end
				dtss_pkg::OP_POP: begin
					if (!stopping_q) begin
						if (rdy_found) begin
							executed <= 1'b1;
							token_out <= stok_q[rdy_idx];
						end else if (dly_found) begin
							has_delayed <= 1'b1;
							wait_ms <= dly_due - now_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign pending_count = 5'(count_q);

	// no new word while a result waits
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> in_stall)
		else $error("input taken while result pending");
	// pending count matches the used bits
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("pending count out of step");
	// executed and has_delayed never together
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !(executed && has_delayed))
		else $error("executed and delayed both set");
	// stop never clears
	assert property (@(posedge clk) disable iff (!arst_n) $past(stopping_q) |-> stopping_q)
		else $error("stopping flag cleared");

endmodule
